>>> design/plist_pkg.sv
// Shared types, codes and defaults for the positional list engine.
`default_nettype none

package plist_pkg;

   localparam int DEPTH_DEFAULT = 16;

   // Request action codes.
   localparam logic [2:0] ACT_APPEND      = 3'd0;
   localparam logic [2:0] ACT_INSERT      = 3'd1;
   localparam logic [2:0] ACT_REMOVE_TAIL = 3'd2;
   localparam logic [2:0] ACT_REMOVE_AT   = 3'd3;
   localparam logic [2:0] ACT_COUNT       = 3'd4;

   // Result status codes.
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_EMPTY  = 2'd1;
   localparam logic [1:0] ST_FULL   = 2'd2;
   localparam logic [1:0] ST_BADPOS = 2'd3;

   // Work plan chosen by the datapath when a transaction is captured.
   localparam logic [1:0] PLAN_RESPOND = 2'd0;
   localparam logic [1:0] PLAN_WRITE   = 2'd1;
   localparam logic [1:0] PLAN_INSERT  = 2'd2;
   localparam logic [1:0] PLAN_REMOVE  = 2'd3;

   typedef struct packed {
      logic [2:0]         action;
      logic [4:0]         position;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] removed_value;
      logic [4:0]         entry_count;
      logic [1:0]         status;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic write_value;
      logic read_fetch;
      logic grab;
      logic read_src;
      logic move;
   } plist_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [1:0] plan;
      logic       moves_zero;
      logic       moves_last;
   } plist_stat_type;

endpackage

`default_nettype wire

>>> design/plist_ctrl.sv
// Sequencing state machine of the positional list engine.
`default_nettype none

module plist_ctrl
   import plist_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           start,
   output logic                busy,
   output logic                rsp_strobe,
   output plist_cmd_type       cmd,
   input  wire plist_stat_type stat
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DISPATCH = 3'd1;
   localparam logic [2:0] S_WRITE    = 3'd2;
   localparam logic [2:0] S_FETCH    = 3'd3;
   localparam logic [2:0] S_GRAB     = 3'd4;
   localparam logic [2:0] S_READ     = 3'd5;
   localparam logic [2:0] S_MOVE     = 3'd6;
   localparam logic [2:0] S_RESP     = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (stat.plan)
               PLAN_WRITE:  state_in = S_WRITE;
               PLAN_INSERT: state_in = S_READ;
               PLAN_REMOVE: state_in = S_FETCH;
               default:     state_in = S_RESP;
            endcase
         end
         S_WRITE: begin
            cmd.write_value = 1'b1;
            state_in        = S_RESP;
         end
         S_FETCH: begin
            cmd.read_fetch = 1'b1;
            state_in       = S_GRAB;
         end
         S_GRAB: begin
            cmd.grab = 1'b1;
            state_in = stat.moves_zero ? S_RESP : S_READ;
         end
         S_READ: begin
            cmd.read_src = 1'b1;
            state_in     = S_MOVE;
         end
         S_MOVE: begin
            cmd.move = 1'b1;
            if (stat.moves_last) begin
               // An insert still has to drop the new value into the opened slot.
               state_in = (stat.plan == PLAN_INSERT) ? S_WRITE : S_RESP;
            end else begin
               state_in = S_READ;
            end
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = (state_ff == S_RESP);

endmodule

`default_nettype wire

>>> design/plist_dp.sv
// Datapath of the positional list engine: entry memory, length and result registers.
`default_nettype none

module plist_dp
   import plist_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
)
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire req_type       req_data,
   input  wire plist_cmd_type cmd,
   output plist_stat_type     stat,
   output rsp_type            rsp_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LW = $clog2(DEPTH + 1);
   localparam int CW = ((LW > 5) ? LW : 5) + 1;

   logic signed [31:0] mem [DEPTH];
   logic signed [31:0] rd_data_ff;

   logic [LW-1:0]      length_ff, length_in;
   logic [1:0]         plan_ff, plan_in;
   logic [1:0]         status_ff, status_in;
   logic [AW-1:0]      tgt_ff, tgt_in;
   logic [AW-1:0]      ptr_ff, ptr_in;
   logic [LW-1:0]      moves_ff, moves_in;
   logic signed [31:0] value_ff;
   logic signed [31:0] removed_ff;

   logic [CW-1:0]      len_c, pos_c, depth_c, span_c;
   logic [AW-1:0]      rd_addr, wr_addr;
   logic signed [31:0] wr_data;
   logic               wr_en;

   // Decode of a new transaction against the current length.
   always_comb begin
      len_c     = CW'(length_ff);
      pos_c     = CW'(req_data.position);
      depth_c   = CW'(DEPTH);
      span_c    = '0;
      plan_in   = PLAN_RESPOND;
      status_in = ST_OK;
      tgt_in    = '0;
      ptr_in    = '0;
      moves_in  = '0;
      length_in = length_ff;
      unique case (req_data.action)
         ACT_APPEND: begin
            if (len_c >= depth_c) begin
               status_in = ST_FULL;
            end else begin
               plan_in   = PLAN_WRITE;
               tgt_in    = AW'(length_ff);
               length_in = length_ff + LW'(1);
            end
         end
         ACT_INSERT: begin
            if (len_c == '0) begin
               plan_in   = PLAN_WRITE;
               length_in = LW'(1);
            end else if (len_c >= depth_c) begin
               status_in = ST_FULL;
            end else if (pos_c == '0 || pos_c > len_c + CW'(1)) begin
               status_in = ST_BADPOS;
            end else begin
               span_c    = len_c + CW'(1) - pos_c;
               tgt_in    = AW'(pos_c - CW'(1));
               ptr_in    = AW'(len_c - CW'(1));
               moves_in  = LW'(span_c);
               plan_in   = (span_c == '0) ? PLAN_WRITE : PLAN_INSERT;
               length_in = length_ff + LW'(1);
            end
         end
         ACT_REMOVE_TAIL: begin
            if (len_c == '0) begin
               status_in = ST_EMPTY;
            end else begin
               plan_in   = PLAN_REMOVE;
               tgt_in    = AW'(len_c - CW'(1));
               length_in = length_ff - LW'(1);
            end
         end
         ACT_REMOVE_AT: begin
            if (len_c == '0) begin
               status_in = ST_EMPTY;
            end else if (pos_c == '0 || pos_c > len_c) begin
               status_in = ST_BADPOS;
            end else begin
               plan_in   = PLAN_REMOVE;
               tgt_in    = AW'(pos_c - CW'(1));
               ptr_in    = AW'(pos_c);
               moves_in  = LW'(len_c - pos_c);
               length_in = length_ff - LW'(1);
            end
         end
         default: begin
            plan_in = PLAN_RESPOND;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= '0;
         plan_ff   <= PLAN_RESPOND;
      end else if (cmd.capture) begin
         length_ff <= length_in;
         plan_ff   <= plan_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         status_ff  <= status_in;
         tgt_ff     <= tgt_in;
         ptr_ff     <= ptr_in;
         moves_ff   <= moves_in;
         value_ff   <= req_data.value;
         removed_ff <= '0;
      end else begin
         if (cmd.move) begin
            ptr_ff   <= (plan_ff == PLAN_INSERT) ? ptr_ff - AW'(1) : ptr_ff + AW'(1);
            moves_ff <= moves_ff - LW'(1);
         end
         if (cmd.grab) begin
            removed_ff <= rd_data_ff;
         end
      end
   end

   // Single read port, single write port memory.
   assign rd_addr = cmd.read_fetch ? tgt_ff : ptr_ff;
   assign wr_en   = cmd.write_value || cmd.move;
   assign wr_data = cmd.move ? rd_data_ff : value_ff;

   always_comb begin
      if (cmd.move) begin
         wr_addr = (plan_ff == PLAN_INSERT) ? ptr_ff + AW'(1) : ptr_ff - AW'(1);
      end else begin
         wr_addr = tgt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read_fetch || cmd.read_src) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   assign stat.plan       = plan_ff;
   assign stat.moves_zero = (moves_ff == '0);
   assign stat.moves_last = (moves_ff == LW'(1));

   assign rsp_data.removed_value = removed_ff;
   assign rsp_data.entry_count   = 5'(length_ff);
   assign rsp_data.status        = status_ff;

endmodule

`default_nettype wire

>>> design/positional_list_engine_top.sv
// Top level of the positional list engine.
`default_nettype none

// The engine keeps an ordered list of up to DEPTH signed 32-bit values in a
// single-port-read, single-port-write memory. A transaction is accepted on a
// rising edge where start is high and busy is low, and each transaction
// produces exactly one result, shown on rsp_data for a single clock cycle
// while rsp_strobe is high. The receiver cannot stall the engine, so it must
// take every result in the cycle it appears. Busy stays high from acceptance
// until the cycle after the result strobe. The steps depend on the request:
// count requests and failed requests go from dispatch straight to the
// result; append, tail insert and insert into an empty list first write
// the value; an insert that moves entries shifts them one by one toward
// the tail, starting from the last, and then writes the new value; a
// removal reads and keeps the removed entry, then shifts each later entry
// toward the head. Each entry is moved by a read and then a write through
// the single memory ports. Removals return the removed value; every result
// carries the entry count after the request, masked to five bits, and a status
// of ok, empty, full or bad position. There is no clearing pass after reset:
// only the length and the plan are cleared; entries beyond it are never read.

module positional_list_engine_top
   import plist_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
)
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_strobe,
   output rsp_type      rsp_data
);

   plist_cmd_type  cmd;
   plist_stat_type stat;

   // The controller walks each transaction through dispatch, memory moves
   // and the result cycle.
   plist_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .stat       (stat)
   );

   // The datapath decodes the request, holds the list and builds the result.
   plist_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

>>> design/plist_checker.sv
// Port-level checks of the positional list engine and their bind.
`default_nettype none

module plist_checker
   import plist_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire logic    rsp_strobe,
   input wire rsp_type rsp_data
);

   // An accepted transaction makes the engine busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("engine not busy after an accepted transaction");

   // A result lasts exactly one cycle and ends the transaction.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> (!rsp_strobe && !busy))
      else $error("result strobe longer than one cycle or busy held");

   // A result only appears inside a transaction.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result strobe outside a transaction");

   // A failed request never reports a removed value.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status != ST_OK) |-> (rsp_data.removed_value == '0))
      else $error("failed request returned a value");

   // An empty status means the list holds nothing.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status == ST_EMPTY) |-> (rsp_data.entry_count == '0))
      else $error("empty status with a nonzero count");

endmodule

bind positional_list_engine_top plist_checker u_plist_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

`default_nettype wire

>>> sim/tb.sv
// Self-checking testbench for the positional list engine: directed plan, then random traffic.
`timescale 1ns / 1ps

module tb
   import plist_pkg::*;
();

   localparam int DEPTH = DEPTH_DEFAULT;

   // Action codes the engine does not define. They must behave like a count request.
   localparam logic [2:0] ACT_SPARE_5 = 3'd5;
   localparam logic [2:0] ACT_SPARE_6 = 3'd6;
   localparam logic [2:0] ACT_SPARE_7 = 3'd7;

   // Values that sit on the edges of the signed 32-bit range.
   localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

   // Hard limit on the run: far beyond the slowest legal run, which moves at most
   // fifteen entries per transaction and idles between transactions.
   localparam int RUN_LIMIT_NS = 5_000_000;

   // Cycles allowed after the last expected result, to catch stray strobes.
   localparam int TAIL_CYCLES = 40;

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   // One line of the directed plan. When pinned is set, the expected result is
   // the one typed into the plan; otherwise it comes from the shadow list.
   // Rows with reps above one repeat the request with a fresh random value.
   typedef struct {
      req_type req;
      int      reps;
      bit      pinned;
      rsp_type want;
   } plan_row_type;

   // Shadow copy of the list contents and length, advanced once per
   // accepted transaction.
   logic signed [31:0] shadow_entries [DEPTH];
   int                 shadow_len;

   // Results the engine still owes, oldest first.
   rsp_type awaited_rsps [$];

   int error_count = 0;

   positional_list_engine_top #(
      .DEPTH (DEPTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always #5 clock = ~clock;

   // Advances the shadow list by one request and returns the result the
   // engine must give for it. Inserting into an empty list ignores the
   // position; position length+1 on insert lands at the tail.
   task automatic shadow_step(input req_type r, output rsp_type res);
      int i;
      int p;
      p = r.position;
      res.removed_value = '0;
      res.status        = ST_OK;
      case (r.action)
         ACT_APPEND: begin
            if (shadow_len >= DEPTH) begin
               res.status = ST_FULL;
            end else begin
               shadow_entries[shadow_len] = r.value;
               shadow_len++;
            end
         end
         ACT_INSERT: begin
            if (shadow_len == 0) begin
               shadow_entries[0] = r.value;
               shadow_len = 1;
            end else if (shadow_len >= DEPTH) begin
               res.status = ST_FULL;
            end else if (p == 0 || p > shadow_len + 1) begin
               res.status = ST_BADPOS;
            end else begin
               for (i = shadow_len; i > p - 1; i--) begin
                  shadow_entries[i] = shadow_entries[i - 1];
               end
               shadow_entries[p - 1] = r.value;
               shadow_len++;
            end
         end
         ACT_REMOVE_TAIL: begin
            if (shadow_len == 0) begin
               res.status = ST_EMPTY;
            end else begin
               res.removed_value = shadow_entries[shadow_len - 1];
               shadow_len--;
            end
         end
         ACT_REMOVE_AT: begin
            if (shadow_len == 0) begin
               res.status = ST_EMPTY;
            end else if (p == 0 || p > shadow_len) begin
               res.status = ST_BADPOS;
            end else begin
               res.removed_value = shadow_entries[p - 1];
               for (i = p - 1; i + 1 < shadow_len; i++) begin
                  shadow_entries[i] = shadow_entries[i + 1];
               end
               shadow_len--;
            end
         end
         default: begin
            // Count and the spare codes leave the list alone.
         end
      endcase
      res.entry_count = 5'(shadow_len);
   endtask

   function automatic plan_row_type plan_row(input logic [2:0] act, input logic [4:0] pos,
                                             input logic signed [31:0] val, input int reps,
                                             input bit pinned, input logic signed [31:0] rm,
                                             input logic [4:0] cnt, input logic [1:0] st);
      plan_row_type pr;
      pr.req.action        = act;
      pr.req.position      = pos;
      pr.req.value         = val;
      pr.reps              = reps;
      pr.pinned            = pinned;
      pr.want.removed_value = rm;
      pr.want.entry_count  = cnt;
      pr.want.status       = st;
      return pr;
   endfunction

   // Draws a random value, with the range edges and the small specials mixed in.
   function automatic logic signed [31:0] pick_value();
      if ($urandom_range(0, 9) != 0) begin
         return $urandom;
      end
      case ($urandom_range(0, 3))
         0:       return VAL_MAX;
         1:       return VAL_MIN;
         2:       return '0;
         default: return '1;
      endcase
   endfunction

   // Draws one random request. fill_bias is the percentage of list-changing
   // requests that grow the list, so the run wanders between empty and full.
   // Most positions are legal for the current length; the rest cover the
   // whole five-bit field to reach the bad position cases.
   function automatic req_type pick_request(input int fill_bias);
      req_type r;
      int      roll;
      roll       = $urandom_range(0, 99);
      r.value    = pick_value();
      r.position = 5'($urandom_range(0, 31));
      if (roll < 3) begin
         case ($urandom_range(0, 2))
            0:       r.action = ACT_SPARE_5;
            1:       r.action = ACT_SPARE_6;
            default: r.action = ACT_SPARE_7;
         endcase
      end else if (roll < 8) begin
         r.action = ACT_COUNT;
      end else if ($urandom_range(0, 99) < fill_bias) begin
         r.action = $urandom_range(0, 1) ? ACT_APPEND : ACT_INSERT;
      end else begin
         r.action = $urandom_range(0, 1) ? ACT_REMOVE_TAIL : ACT_REMOVE_AT;
      end
      if ($urandom_range(0, 99) >= 12) begin
         if (r.action == ACT_INSERT) begin
            r.position = 5'($urandom_range(1, shadow_len + 1));
         end else if (r.action == ACT_REMOVE_AT && shadow_len > 0) begin
            r.position = 5'($urandom_range(1, shadow_len));
         end
      end
      return r;
   endfunction

   // Offers one transaction and holds it until the engine takes it. Before
   // offering, the sender may sit idle for a random number of cycles, each
   // cycle idle with probability idle_pct. Start is only lowered when a gap
   // is taken, so back-to-back transactions keep it high.
   task automatic send_request(input req_type r, input bit pinned, input rsp_type want,
                               input int idle_pct);
      rsp_type predicted;
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < idle_pct);
      end
      start    <= 1'b1;
      req_data <= r;
      // Start is high at every edge below; the transaction goes in at the
      // first one where busy is low.
      do @(posedge clock); while (busy !== 1'b0);
      shadow_step(r, predicted);
      awaited_rsps.push_back(pinned ? want : predicted);
   endtask

   // Stops offering and waits until the engine has returned every result it owes.
   // At least one edge passes, so start is never lowered and raised in one step.
   task automatic drain_results();
      start <= 1'b0;
      do @(posedge clock); while (awaited_rsps.size() != 0);
   endtask

   // Result checker. Every strobe must match the oldest outstanding expectation,
   // field by field. The engine cannot be stalled, so a result is taken in the
   // cycle it is shown.
   always @(posedge clock) begin
      rsp_type want;
      if (reset === 1'b0 && rsp_strobe === 1'b1) begin
         if (awaited_rsps.size() == 0) begin
            $display("%0t: result with nothing expected: removed_value %0d count %0d status %0d",
                     $time, rsp_data.removed_value, rsp_data.entry_count, rsp_data.status);
            error_count++;
         end else begin
            want = awaited_rsps.pop_front();
            if (rsp_data.removed_value !== want.removed_value) begin
               $display("%0t: removed_value expected %0d got %0d",
                        $time, want.removed_value, rsp_data.removed_value);
               error_count++;
            end
            if (rsp_data.entry_count !== want.entry_count) begin
               $display("%0t: entry_count expected %0d got %0d",
                        $time, want.entry_count, rsp_data.entry_count);
               error_count++;
            end
            if (rsp_data.status !== want.status) begin
               $display("%0t: status expected %0d got %0d",
                        $time, want.status, rsp_data.status);
               error_count++;
            end
         end
      end
   end

   // Stimulus: reset, the directed plan, then random traffic in phases.
   initial begin
      plan_row_type plan_rows [$];
      plan_row_type pr;
      req_type      r;
      rsp_type      no_pin;
      int           idle_by_phase [3];
      int           ph;
      int           n;
      int           fill_bias;

      reset      <= 1'b1;
      start      <= 1'b0;
      req_data   <= '0;
      shadow_len = 0;
      no_pin     = '0;

      // The directed plan starts from the empty list left by reset. Pinned rows
      // carry results that follow directly from the request and the count.
      // Empty list: count, and both kinds of removal fail as empty.
      plan_rows.push_back(plan_row(ACT_COUNT,       5'd0,  0,       1, 1, 0,       5'd0,  ST_OK));
      plan_rows.push_back(plan_row(ACT_REMOVE_TAIL, 5'd0,  0,       1, 1, 0,       5'd0,  ST_EMPTY));
      plan_rows.push_back(plan_row(ACT_REMOVE_AT,   5'd1,  0,       1, 1, 0,       5'd0,  ST_EMPTY));
      plan_rows.push_back(plan_row(ACT_REMOVE_AT,   5'd0,  0,       1, 1, 0,       5'd0,  ST_EMPTY));
      // Insert into an empty list accepts any position, zero and the top of
      // the field included. Removing the only entry empties the list.
      plan_rows.push_back(plan_row(ACT_INSERT,      5'd0,  VAL_MAX, 1, 1, 0,       5'd1,  ST_OK));
      plan_rows.push_back(plan_row(ACT_REMOVE_TAIL, 5'd0,  0,       1, 1, VAL_MAX, 5'd0,  ST_OK));
      plan_rows.push_back(plan_row(ACT_INSERT,      5'd31, VAL_MIN, 1, 1, 0,       5'd1,  ST_OK));
      plan_rows.push_back(plan_row(ACT_APPEND,      5'd0,  -1,      1, 1, 0,       5'd2,  ST_OK));
      // Insert at position zero and past length+1 are rejected.
      plan_rows.push_back(plan_row(ACT_INSERT,      5'd0,  5,       1, 1, 0,       5'd2,  ST_BADPOS));
      plan_rows.push_back(plan_row(ACT_INSERT,      5'd4,  5,       1, 1, 0,       5'd2,  ST_BADPOS));
      // Insert at the tail, the head and the middle.
      plan_rows.push_back(plan_row(ACT_INSERT,      5'd3,  32'sh1234_5678, 1, 0, 0, 5'd0, ST_OK));
      plan_rows.push_back(plan_row(ACT_INSERT,      5'd1,  0,       1, 0, 0,       5'd0,  ST_OK));
      plan_rows.push_back(plan_row(ACT_INSERT,      5'd2,  32'sh5555_5555, 1, 0, 0, 5'd0, ST_OK));
      // Remove at position zero and past length are rejected; then real removals.
      plan_rows.push_back(plan_row(ACT_REMOVE_AT,   5'd0,  0,       1, 1, 0,       5'd5,  ST_BADPOS));
      plan_rows.push_back(plan_row(ACT_REMOVE_AT,   5'd6,  0,       1, 1, 0,       5'd5,  ST_BADPOS));
      plan_rows.push_back(plan_row(ACT_REMOVE_AT,   5'd3,  0,       1, 0, 0,       5'd0,  ST_OK));
      plan_rows.push_back(plan_row(ACT_REMOVE_AT,   5'd1,  0,       1, 0, 0,       5'd0,  ST_OK));
      // The spare action codes act as a count.
      plan_rows.push_back(plan_row(ACT_SPARE_5,     5'd31, -1,      1, 1, 0,       5'd3,  ST_OK));
      plan_rows.push_back(plan_row(ACT_SPARE_6,     5'd0,  0,       1, 1, 0,       5'd3,  ST_OK));
      plan_rows.push_back(plan_row(ACT_SPARE_7,     5'd16, VAL_MIN, 1, 1, 0,       5'd3,  ST_OK));
      // Fill the list to capacity with random values.
      plan_rows.push_back(plan_row(ACT_APPEND,      5'd0,  0,       DEPTH - 3, 0, 0, 5'd0, ST_OK));
      // Full list: both ways of adding fail as full, count reports capacity, position 17 is bad.
      plan_rows.push_back(plan_row(ACT_APPEND,      5'd0,  1,       1, 1, 0,       5'd16, ST_FULL));
      plan_rows.push_back(plan_row(ACT_INSERT,      5'd1,  1,       1, 1, 0,       5'd16, ST_FULL));
      plan_rows.push_back(plan_row(ACT_INSERT,      5'd31, 1,       1, 1, 0,       5'd16, ST_FULL));
      plan_rows.push_back(plan_row(ACT_COUNT,       5'd0,  0,       1, 1, 0,       5'd16, ST_OK));
      plan_rows.push_back(plan_row(ACT_REMOVE_AT,   5'd17, 0,       1, 1, 0,       5'd16, ST_BADPOS));
      // Tail removal, tail insert by position, head insert into the full list, and the longest removal move.
      plan_rows.push_back(plan_row(ACT_REMOVE_TAIL, 5'd0,  0,       1, 0, 0,       5'd0,  ST_OK));
      plan_rows.push_back(plan_row(ACT_INSERT,      5'd16, VAL_MAX, 1, 0, 0,       5'd0,  ST_OK));
      plan_rows.push_back(plan_row(ACT_INSERT,      5'd1,  VAL_MIN, 1, 0, 0,       5'd0,  ST_OK));
      plan_rows.push_back(plan_row(ACT_REMOVE_AT,   5'd1,  0,       1, 0, 0,       5'd0,  ST_OK));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part, sent back to back.
      foreach (plan_rows[k]) begin
         pr = plan_rows[k];
         for (n = 0; n < pr.reps; n++) begin
            r = pr.req;
            if (pr.reps > 1) begin
               r.value = $urandom;
            end
            send_request(r, pr.pinned, pr.want, 0);
         end
      end
      drain_results();

      // Random part. The phases differ in how often the sender sits idle:
      // never, in most cycles, and in about a third. The result side cannot
      // be held off, so only the sender idles. Each phase ends by letting
      // every outstanding result come back before more traffic is offered.
      idle_by_phase = '{0, 64, 37};
      for (ph = 0; ph < 3; ph++) begin
         fill_bias = 50;
         for (n = 0; n < 250; n++) begin
            // Every fifty transactions, lean toward filling, draining or neither.
            if (n % 50 == 0) begin
               case ($urandom_range(0, 2))
                  0:       fill_bias = 20;
                  1:       fill_bias = 50;
                  default: fill_bias = 85;
               endcase
            end
            send_request(pick_request(fill_bias), 1'b0, no_pin, idle_by_phase[ph]);
         end
         drain_results();
      end

      // Every transaction has produced its result. Watch a little longer for
      // any stray strobe before the verdict.
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Watchdog for a hung handshake or missing results.
   initial begin
      #(RUN_LIMIT_NS);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

>>> positional_list_engine_top.f
design/plist_pkg.sv
design/plist_ctrl.sv
design/plist_dp.sv
design/positional_list_engine_top.sv
design/plist_checker.sv
sim/tb.sv
